// ----- rtl/assert_macros.svh -----
// Assertion macros for the point filter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LSPF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LSPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define LSPF_ASSERT(label, clk, rst_n, prop, msg)
`define LSPF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/lspf_pkg.sv -----
// Shared types, constants and tables for the scan point filter
package lspf_pkg;

    localparam int MAX_POINTS_DEF    = 2048;
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 18;

    localparam int RANGE_W    = 18;
    localparam int COORD_W    = 19;
    localparam int ANG_W      = 16;
    localparam int DIST_W     = 12;
    localparam int IDX_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int ENTRY_W    = 2 * COORD_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_DIST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DIST = 3'd5;

    localparam logic [ANG_W-1:0]   RST_ANGLE_START = 16'h8000;
    localparam logic [ANG_W-1:0]   RST_ANGLE_STEP  = 16'd64;
    localparam logic [RANGE_W-1:0] RST_RANGE_LOW   = 18'd0;
    localparam logic [RANGE_W-1:0] RST_RANGE_HIGH  = 18'd262142;
    localparam logic [DIST_W-1:0]  RST_NOISE_DIST  = 12'd12;
    localparam logic [DIST_W-1:0]  RST_SAMPLE_DIST = 12'd4;

    localparam logic [29:0] GAIN_Q30 = 30'd652032874;
    localparam int COORD_MAX = 262143;

    typedef struct packed {
        logic take;
        logic calc;
        logic rot_start;
        logic scan_start;
        logic scan_run;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic cordic_done;
        logic scan_done;
        logic out_busy;
    } stat_t;

    function automatic logic [31:0] atan_q32(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/lspf_if.sv -----
// Sample and point channel interfaces
interface lspf_in_if;
    import lspf_pkg::*;
    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] range_sample;
    logic               scan_end;
    modport source (output valid, range_sample, scan_end, input ready);
    modport sink (input valid, range_sample, scan_end, output ready);
endinterface

interface lspf_out_if;
    import lspf_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic                      kept;
    logic                      end_of_scan;
    modport source (output valid, pos_x, pos_y, kept, end_of_scan, input ready);
    modport sink (input valid, pos_x, pos_y, kept, end_of_scan, output ready);
endinterface

// ----- rtl/lspf_ram.sv -----
// Generic simple dual port RAM with registered read
module lspf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/lspf_cordic.sv -----
// Iterative CORDIC rotation of a range sample to x,y
module lspf_cordic #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 18
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [lspf_pkg::RANGE_W-1:0]       range_in,
    input  logic [ANGLE_BITS-1:0]              angle,
    output logic                               done,
    output logic signed [lspf_pkg::COORD_W-1:0] pos_x,
    output logic signed [lspf_pkg::COORD_W-1:0] pos_y
);
    import lspf_pkg::*;

    localparam int SW = $clog2(CORDIC_STAGES);
    localparam int XW = 37;
    localparam int ZW = 33;
    localparam logic [ANGLE_BITS-1:0] HALF_Q = ANGLE_BITS'(1) << (ANGLE_BITS - 3);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_LOAD  = 2'd1;
    localparam logic [1:0] PH_ITER  = 2'd2;
    localparam logic [1:0] PH_ROUND = 2'd3;

    logic [1:0]                  phase_reg, phase_next;
    logic [SW-1:0]               step_reg;
    logic [47:0]                 gprod_reg;
    logic [1:0]                  quad_reg;
    logic signed [XW-1:0]        x_reg, y_reg;
    logic signed [ZW-1:0]        z_reg;
    logic signed [COORD_W-1:0]   px_reg, py_reg;
    logic                        done_reg;

    logic [ANGLE_BITS-1:0]       fold_sum, resid;
    logic [1:0]                  quad;
    logic signed [ZW-1:0]        z_init;
    logic signed [XW-1:0]        dx, dy;
    logic signed [ZW-1:0]        atan_v;
    logic signed [XW-1:0]        xr, yr;
    logic signed [COORD_W-1:0]   xc, yc, qx, qy;

    always_comb
    begin
        fold_sum = angle + HALF_Q;
        quad     = fold_sum[ANGLE_BITS-1 -: 2];
        resid    = angle - {quad, {(ANGLE_BITS-2){1'b0}}};
        z_init   = {{(ZW-ANGLE_BITS){resid[ANGLE_BITS-1]}}, resid} << (32 - ANGLE_BITS);
    end

    always_comb
    begin
        dx     = y_reg >>> step_reg;
        dy     = x_reg >>> step_reg;
        atan_v = {1'b0, atan_q32(5'(step_reg))};
    end

    always_comb
    begin
        xr = (x_reg + XW'(32768)) >>> 16;
        yr = (y_reg + XW'(32768)) >>> 16;
        if (xr > XW'(COORD_MAX))
            xc = COORD_W'(COORD_MAX);
        else if (xr < -XW'(COORD_MAX))
            xc = -COORD_W'(COORD_MAX);
        else
            xc = xr[COORD_W-1:0];
        if (yr > XW'(COORD_MAX))
            yc = COORD_W'(COORD_MAX);
        else if (yr < -XW'(COORD_MAX))
            yc = -COORD_W'(COORD_MAX);
        else
            yc = yr[COORD_W-1:0];
        case (quad_reg)
            2'd0:
            begin
                qx = xc;
                qy = yc;
            end
            2'd1:
            begin
                qx = -yc;
                qy = xc;
            end
            2'd2:
            begin
                qx = -xc;
                qy = -yc;
            end
            default:
            begin
                qx = yc;
                qy = -xc;
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:  if (start) phase_next = PH_LOAD;
            PH_LOAD:  phase_next = PH_ITER;
            PH_ITER:  if (step_reg == SW'(CORDIC_STAGES - 1)) phase_next = PH_ROUND;
            PH_ROUND: phase_next = PH_IDLE;
            default:  phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == PH_ROUND);
            if (phase_reg == PH_LOAD)
                step_reg <= '0;
            else if (phase_reg == PH_ITER)
                step_reg <= step_reg + SW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && start)
        begin
            gprod_reg <= range_in * GAIN_Q30;
            quad_reg  <= quad;
            z_reg     <= z_init;
        end
        if (phase_reg == PH_LOAD)
        begin
            x_reg <= {3'b000, gprod_reg[47:14]};
            y_reg <= '0;
        end
        if (phase_reg == PH_ITER)
        begin
            if (!z_reg[ZW-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_v;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_v;
            end
        end
        if (phase_reg == PH_ROUND)
        begin
            px_reg <= qx;
            py_reg <= qy;
        end
    end

    assign done  = done_reg;
    assign pos_x = px_reg;
    assign pos_y = py_reg;
endmodule

// ----- rtl/lspf_datapath.sv -----
// Datapath: config registers, angle, rotation, store scan and result register
module lspf_datapath #(
    parameter int MAX_POINTS    = 2048,
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 18
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lspf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lspf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [lspf_pkg::RANGE_W-1:0]        range_sample,
    input  logic                                scan_end,
    input  lspf_pkg::cmd_t                      cmd,
    output lspf_pkg::stat_t                     stat,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [lspf_pkg::COORD_W-1:0] pos_x,
    output logic signed [lspf_pkg::COORD_W-1:0] pos_y,
    output logic                                kept,
    output logic                                end_of_scan
);
    import lspf_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [ANG_W-1:0]   angle_start_reg, angle_step_reg;
    logic [RANGE_W-1:0] range_low_reg, range_high_reg;
    logic [DIST_W-1:0]  noise_dist_reg, sample_dist_reg;

    logic [RANGE_W-1:0]    range_reg;
    logic                  last_reg, inr_reg;
    logic [ANGLE_BITS-1:0] angle_reg;
    logic [2*DIST_W-1:0]   nd2_reg, sd2_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [CW-1:0]         count_reg, addr_reg;

    logic                  v1_reg, v2_reg, v3_reg;
    logic                  live2_reg, live3_reg;
    logic signed [COORD_W:0]     dx_reg, dy_reg;
    logic signed [2*COORD_W+1:0] sqx_reg, sqy_reg;
    logic                  noisy_reg, close_reg;

    logic                      out_valid_reg, kept_reg, eos_reg;
    logic signed [COORD_W-1:0] ox_reg, oy_reg;

    logic                      in_range_now;
    logic [31:0]               angle_prod, angle_sum;
    logic                      cdone;
    logic signed [COORD_W-1:0] cx, cy;
    logic                      rd_en;
    logic [ENTRY_W-1:0]        rdata, wdata;
    logic signed [COORD_W-1:0] sx, sy;
    logic [2*COORD_W+2:0]      dsum;
    logic                      full, kept_now, wr_en;
    logic signed [COORD_W-1:0] res_x, res_y, st_x, st_y;

    assign in_range_now = (range_sample > range_low_reg) && (range_sample < range_high_reg);
    assign angle_prod   = idx_reg * angle_step_reg;
    assign angle_sum    = {{(32-ANG_W){angle_start_reg[ANG_W-1]}}, angle_start_reg} + angle_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_start_reg <= RST_ANGLE_START;
            angle_step_reg  <= RST_ANGLE_STEP;
            range_low_reg   <= RST_RANGE_LOW;
            range_high_reg  <= RST_RANGE_HIGH;
            noise_dist_reg  <= RST_NOISE_DIST;
            sample_dist_reg <= RST_SAMPLE_DIST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ANGLE_START: angle_start_reg <= cfg_wdata[ANG_W-1:0];
                REG_ANGLE_STEP:  angle_step_reg  <= cfg_wdata[ANG_W-1:0];
                REG_RANGE_LOW:   range_low_reg   <= cfg_wdata[RANGE_W-1:0];
                REG_RANGE_HIGH:  range_high_reg  <= cfg_wdata[RANGE_W-1:0];
                REG_NOISE_DIST:  noise_dist_reg  <= cfg_wdata[DIST_W-1:0];
                REG_SAMPLE_DIST: sample_dist_reg <= cfg_wdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    lspf_cordic #(
        .ANGLE_BITS    (ANGLE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.rot_start),
        .range_in (range_reg),
        .angle    (angle_reg),
        .done     (cdone),
        .pos_x    (cx),
        .pos_y    (cy)
    );

    assign rd_en = cmd.scan_run && (addr_reg < count_reg);

    lspf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (addr_reg[AW-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        sx       = rdata[ENTRY_W-1 -: COORD_W];
        sy       = rdata[COORD_W:1];
        dsum     = (2*COORD_W+3)'(sqx_reg) + (2*COORD_W+3)'(sqy_reg);
        full     = (count_reg >= CW'(MAX_POINTS));
        kept_now = inr_reg && !noisy_reg && !close_reg && (cx != '0 || cy != '0);
        res_x    = inr_reg ? cx : '0;
        res_y    = inr_reg ? cy : '0;
        st_x     = noisy_reg ? '0 : cx;
        st_y     = noisy_reg ? '0 : cy;
        wdata    = {st_x, st_y, kept_now};
        wr_en    = cmd.finish && inr_reg && !full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inr_reg       <= 1'b0;
            last_reg      <= 1'b0;
            idx_reg       <= '0;
            count_reg     <= '0;
            addr_reg      <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            noisy_reg     <= 1'b0;
            close_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                inr_reg  <= in_range_now;
                last_reg <= scan_end;
            end
            if (cmd.scan_start)
            begin
                addr_reg  <= '0;
                noisy_reg <= 1'b0;
                close_reg <= 1'b0;
                v1_reg    <= 1'b0;
                v2_reg    <= 1'b0;
                v3_reg    <= 1'b0;
            end
            else
            begin
                if (rd_en)
                    addr_reg <= addr_reg + CW'(1);
                v1_reg <= rd_en;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                if (v3_reg && dsum < (2*COORD_W+3)'(nd2_reg))
                    noisy_reg <= 1'b1;
                if (v3_reg && live3_reg && dsum < (2*COORD_W+3)'(sd2_reg))
                    close_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    idx_reg   <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (wr_en)
                        count_reg <= count_reg + CW'(1);
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            range_reg <= range_sample;
        if (cmd.calc)
        begin
            angle_reg <= angle_sum[ANGLE_BITS-1:0];
            nd2_reg   <= noise_dist_reg * noise_dist_reg;
            sd2_reg   <= sample_dist_reg * sample_dist_reg;
        end
        dx_reg    <= {cx[COORD_W-1], cx} - {sx[COORD_W-1], sx};
        dy_reg    <= {cy[COORD_W-1], cy} - {sy[COORD_W-1], sy};
        live2_reg <= rdata[0];
        sqx_reg   <= dx_reg * dx_reg;
        sqy_reg   <= dy_reg * dy_reg;
        live3_reg <= live2_reg;
        if (cmd.finish)
        begin
            ox_reg   <= res_x;
            oy_reg   <= res_y;
            kept_reg <= kept_now;
            eos_reg  <= last_reg;
        end
    end

    assign stat.in_range    = in_range_now;
    assign stat.cordic_done = cdone;
    assign stat.scan_done   = (addr_reg >= count_reg) && !v1_reg && !v2_reg && !v3_reg;
    assign stat.out_busy    = out_valid_reg && !out_ready;

    assign out_valid   = out_valid_reg;
    assign pos_x       = ox_reg;
    assign pos_y       = oy_reg;
    assign kept        = kept_reg;
    assign end_of_scan = eos_reg;
endmodule

// ----- rtl/lspf_ctrl.sv -----
// Controller state machine sequencing one item through the datapath
`include "assert_macros.svh"
module lspf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  lspf_pkg::stat_t stat,
    output lspf_pkg::cmd_t  cmd
);
    import lspf_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ANGLE    = 3'd1;
    localparam logic [2:0] S_ROT_GO   = 3'd2;
    localparam logic [2:0] S_ROT_WAIT = 3'd3;
    localparam logic [2:0] S_SCAN_GO  = 3'd4;
    localparam logic [2:0] S_SCAN     = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        in_ready       = (state_reg == S_IDLE);
        cmd            = '0;
        cmd.take       = in_valid && in_ready;
        cmd.calc       = (state_reg == S_ANGLE);
        cmd.rot_start  = (state_reg == S_ROT_GO);
        cmd.scan_start = (state_reg == S_SCAN_GO);
        cmd.scan_run   = (state_reg == S_SCAN);
        cmd.finish     = (state_reg == S_FINISH) && !stat.out_busy;
        state_next     = state_reg;
        case (state_reg)
            S_IDLE:     if (cmd.take) state_next = stat.in_range ? S_ANGLE : S_FINISH;
            S_ANGLE:    state_next = S_ROT_GO;
            S_ROT_GO:   state_next = S_ROT_WAIT;
            S_ROT_WAIT: if (stat.cordic_done) state_next = S_SCAN_GO;
            S_SCAN_GO:  state_next = S_SCAN;
            S_SCAN:     if (stat.scan_done) state_next = S_FINISH;
            S_FINISH:   if (cmd.finish) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `LSPF_ASSERT_NEXT(a_rot_wait, clk, rst_n, cmd.rot_start, state_reg == S_ROT_WAIT, "rotation start not followed by wait")
    `LSPF_ASSERT(a_done_in_wait, clk, rst_n, stat.cordic_done |-> state_reg == S_ROT_WAIT, "rotation done outside wait")
    `LSPF_ASSERT(a_no_overwrite, clk, rst_n, cmd.finish |-> !stat.out_busy, "result overwrites pending item")
endmodule

// ----- rtl/lidar_scan_point_filter.sv -----
// Top level of the lidar scan point filter
// One sample item is processed at a time. An in-range item goes through
// the angle product, a CORDIC rotation of CORDIC_STAGES iterations plus
// load and rounding, a walk over every stored point of the current scan at
// one store read per cycle through a four-deep distance pipeline, and a
// finish step that writes the store and loads the result register once the
// previous result is taken. An out-of-range item goes straight to the finish
// step. The store holds MAX_POINTS points and needs no clearing after reset.
module lidar_scan_point_filter #(
    parameter int MAX_POINTS    = lspf_pkg::MAX_POINTS_DEF,
    parameter int ANGLE_BITS    = lspf_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = lspf_pkg::CORDIC_STAGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lspf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lspf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    lspf_in_if.sink                         samples,
    lspf_out_if.source                      points
);
    import lspf_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    lspf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lspf_datapath #(
        .MAX_POINTS    (MAX_POINTS),
        .ANGLE_BITS    (ANGLE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .range_sample (samples.range_sample),
        .scan_end     (samples.scan_end),
        .cmd          (cmd),
        .stat         (stat),
        .out_ready    (points.ready),
        .out_valid    (points.valid),
        .pos_x        (points.pos_x),
        .pos_y        (points.pos_y),
        .kept         (points.kept),
        .end_of_scan  (points.end_of_scan)
    );
endmodule
